[sv/positional_ordered_list_macros.svh]
// Assertion macros used by the checker file of the ordered list block.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define POL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define POL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/pol_pkg.sv]
// Shared types, codes and widths of the positional ordered list block.
package pol_pkg;

  // Field widths fixed by the transaction format.
  localparam int ACT_W     = 2;
  localparam int POS_W     = 4;
  localparam int DATA_W    = 32;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 16;

  // Requested operation.
  typedef enum logic [ACT_W-1:0] {
    ACT_REMOVE = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // accept the request transaction and load its first result
    logic step;  // load the next dumped entry into the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_more;  // the presented request is a dump of more than one entry
    logic step_last;  // the next dump step loads the tail entry
  } dp_sts_t;

endpackage

[sv/pol_req_if.sv]
// Request channel carrying one list operation per transaction.
interface pol_req_if;
  logic                              valid;
  logic                              ready;
  logic [pol_pkg::ACT_W-1:0]         action;
  logic [pol_pkg::POS_W-1:0]         position;
  logic [pol_pkg::DATA_W-1:0]        ident;
  logic signed [pol_pkg::DATA_W-1:0] amount;

  modport source (output valid, action, position, ident, amount, input ready);
  modport sink (input valid, action, position, ident, amount, output ready);
endinterface

[sv/pol_rsp_if.sv]
// Response channel carrying one result per transaction.
interface pol_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pol_pkg::ST_W-1:0]          status;
  logic [pol_pkg::DATA_W-1:0]        out_ident;
  logic signed [pol_pkg::DATA_W-1:0] out_amount;
  logic                              last;

  modport source (output valid, status, out_ident, out_amount, last, input ready);
  modport sink (input valid, status, out_ident, out_amount, last, output ready);
endinterface

[sv/pol_ctrl.sv]
// Controller: handshakes, result register valid and dump sequencing.
module pol_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  pol_pkg::dp_sts_t   sts,
  output pol_pkg::ctrl_cmd_t cmd
);

  pol_pkg::state_t state;
  pol_pkg::state_t state_next;
  logic            rsp_valid_next;
  logic            slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !rsp_valid || rsp_ready;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pol_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state, handshake and datapath commands.
  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd            = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      pol_pkg::S_IDLE: begin
        req_ready = slot_free;
        if (req_valid && slot_free) begin
          cmd.take       = 1'b1;
          rsp_valid_next = 1'b1;
          if (sts.dump_more) begin
            state_next = pol_pkg::S_DUMP;
          end
        end
      end
      pol_pkg::S_DUMP: begin
        if (slot_free) begin
          cmd.step       = 1'b1;
          rsp_valid_next = 1'b1;
          if (sts.step_last) begin
            state_next = pol_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = pol_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[sv/pol_dp.sv]
// Datapath: entry cells with parallel shift, entry count, dump pointer and result register.
module pol_dp #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pol_pkg::ctrl_cmd_t                cmd,
  output pol_pkg::dp_sts_t                  sts,
  input  logic [pol_pkg::ACT_W-1:0]         action,
  input  logic [pol_pkg::POS_W-1:0]         position,
  input  logic [pol_pkg::DATA_W-1:0]        ident,
  input  logic signed [pol_pkg::DATA_W-1:0] amount,
  output logic [pol_pkg::ST_W-1:0]          status,
  output logic [pol_pkg::DATA_W-1:0]        out_ident,
  output logic signed [pol_pkg::DATA_W-1:0] out_amount,
  output logic                              last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W;

  logic [pol_pkg::DATA_W-1:0]        ids [DEPTH];
  logic signed [pol_pkg::DATA_W-1:0] amts [DEPTH];
  logic [pol_pkg::DATA_W-1:0]        ids_next [DEPTH];
  logic signed [pol_pkg::DATA_W-1:0] amts_next [DEPTH];

  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  dump_idx;
  pol_pkg::action_t  act;
  pol_pkg::status_t  edit_status;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [CMP_W-1:0]  ins_pos;
  logic              is_full;
  logic              do_insert;
  logic              do_remove;

  assign act     = pol_pkg::action_t'(action);
  assign pos_c   = CMP_W'(position);
  assign cnt_c   = CMP_W'(count);
  assign is_full = (count == CNT_W'(DEPTH));
  assign ins_pos = (act == pol_pkg::ACT_APPEND) ? cnt_c : pos_c;

  // Edit checks: a full list rejects first, then the position is checked.
  always_comb begin
    edit_status = pol_pkg::ST_OK;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    case (act)
      pol_pkg::ACT_REMOVE: begin
        if (pos_c >= cnt_c) begin
          edit_status = pol_pkg::ST_RANGE;
        end else begin
          do_remove = 1'b1;
        end
      end
      pol_pkg::ACT_APPEND, pol_pkg::ACT_INSERT: begin
        if (is_full) begin
          edit_status = pol_pkg::ST_FULL;
        end else if (ins_pos > cnt_c) begin
          edit_status = pol_pkg::ST_RANGE;
        end else begin
          do_insert = 1'b1;
        end
      end
      default: begin
        edit_status = pol_pkg::ST_OK;
      end
    endcase
  end

  // Each cell picks its own value, its upper or lower neighbor, or the new entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i > 0) ? i - 1 : 0;
    localparam int NEXT = (i < DEPTH - 1) ? i + 1 : i;
    always_comb begin
      ids_next[i]  = ids[i];
      amts_next[i] = amts[i];
      if (do_insert && (CMP_W'(i) == ins_pos)) begin
        ids_next[i]  = ident;
        amts_next[i] = amount;
      end else if (do_insert && (CMP_W'(i) > ins_pos)) begin
        ids_next[i]  = ids[PREV];
        amts_next[i] = amts[PREV];
      end else if (do_remove && (CMP_W'(i) >= pos_c)) begin
        ids_next[i]  = ids[NEXT];
        amts_next[i] = amts[NEXT];
      end
    end
  end

  // Entry cells shift together in the cycle the edit is taken.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ids  <= ids_next;
      amts <= amts_next;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.take && do_insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.take && do_remove) begin
      count <= count - CNT_W'(1);
    end
  end

  // Status toward the controller.
  assign sts.dump_more = (act == pol_pkg::ACT_DUMP) && (count > CNT_W'(1));
  assign sts.step_last = ((CNT_W'(dump_idx) + CNT_W'(1)) == count);

  // Result register and dump pointer.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (act == pol_pkg::ACT_DUMP) begin
        if (count == '0) begin
          status     <= pol_pkg::ST_EMPTY;
          out_ident  <= '0;
          out_amount <= '0;
          last       <= 1'b1;
        end else begin
          status     <= pol_pkg::ST_OK;
          out_ident  <= ids[0];
          out_amount <= amts[0];
          last       <= (count == CNT_W'(1));
        end
        dump_idx <= IDX_W'(1);
      end else begin
        status     <= edit_status;
        out_ident  <= '0;
        out_amount <= '0;
        last       <= 1'b1;
      end
    end else if (cmd.step) begin
      status     <= pol_pkg::ST_OK;
      out_ident  <= ids[dump_idx];
      out_amount <= amts[dump_idx];
      last       <= sts.step_last;
      dump_idx   <= dump_idx + IDX_W'(1);
    end
  end

endmodule

[sv/positional_ordered_list.sv]
// Top level of the positional ordered list block.
// Keeps an ordered list of up to DEPTH entries (identifier and signed amount)
// in a row of registers, position 0 at the head. A request transaction removes
// the entry at a position, appends at the tail, inserts at a position, or dumps
// the list. An edit shifts the cells from its position on by one place in
// parallel and loads one status result with last set into the output register.
// While results are taken, edits stream at one per cycle and a dump loads one
// cell per cycle. A dump gives one result per stored entry, head first, with
// last on the tail entry; a dump of an empty list gives a single result with
// status empty. No request is accepted while a dump is under way. Append and
// insert on a full list answer full; a position beyond the list answers out
// of range; neither changes the list. Only entries below the count are ever
// read, so the cells need no clearing after reset.
module positional_ordered_list #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  pol_req_if.sink  req,
  pol_rsp_if.source rsp
);

  pol_pkg::ctrl_cmd_t cmd;
  pol_pkg::dp_sts_t   sts;

  // Sequencing and handshakes.
  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // List storage and result register.
  pol_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action     (req.action),
    .position   (req.position),
    .ident      (req.ident),
    .amount     (req.amount),
    .status     (rsp.status),
    .out_ident  (rsp.out_ident),
    .out_amount (rsp.out_amount),
    .last       (rsp.last)
  );

endmodule

[sv/pol_checker.sv]
// Port-level checks of the positional ordered list block and their binding.
`include "positional_ordered_list_macros.svh"

module pol_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic [pol_pkg::ACT_W-1:0]         req_action,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [pol_pkg::ST_W-1:0]          rsp_status,
  input logic [pol_pkg::DATA_W-1:0]        rsp_ident,
  input logic signed [pol_pkg::DATA_W-1:0] rsp_amount,
  input logic                              rsp_last
);

  // No result is offered in the cycle after reset.
  `POL_ASSERT_ALWAYS(a_no_rsp_after_rst, $past(rst) |-> !rsp_valid, "result valid after reset")

  // A stalled result stays offered.
  `POL_ASSERT(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

  // An accepted edit answers in the next cycle with one zero-payload final result.
  `POL_ASSERT(a_edit_result, req_valid && req_ready && (req_action != pol_pkg::ACT_DUMP) |=> rsp_valid && rsp_last && (rsp_ident == '0) && (rsp_amount == '0), "edit transaction without its status result")

  // An empty-list dump result is always the final one.
  `POL_ASSERT(a_empty_last, rsp_valid && (rsp_status == pol_pkg::ST_EMPTY) |-> rsp_last, "empty dump result not marked last")

  // No new request transaction is taken in the middle of a dump.
  `POL_ASSERT(a_no_req_mid_dump, rsp_valid && !rsp_last |-> !req_ready, "request accepted during a dump")

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_ident  (rsp.out_ident),
  .rsp_amount (rsp.out_amount),
  .rsp_last   (rsp.last)
);
